[design/sfvv_pkg.sv]
// sfvv_pkg: shared types, codes and tables for the sql field value validator
// no dependencies; imported by every module of the block
package sfvv_pkg;

    // default ceiling of the character counter
    localparam int unsigned MAX_LENGTH_DEF = 65535;

    // declared value types
    localparam logic [2:0] TYPE_INT      = 3'd0;
    localparam logic [2:0] TYPE_DOUBLE   = 3'd1;
    localparam logic [2:0] TYPE_DATETIME = 3'd2;
    localparam logic [2:0] TYPE_VARCHAR  = 3'd3;
    localparam logic [2:0] TYPE_TEXT     = 3'd4;
    localparam logic [2:0] TYPE_IDENT    = 3'd5;

    // verdict codes
    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_INT      = 3'd1;
    localparam logic [2:0] ERR_DOUBLE   = 3'd2;
    localparam logic [2:0] ERR_DATETIME = 3'd3;
    localparam logic [2:0] ERR_LENGTH   = 3'd4;
    localparam logic [2:0] ERR_IDENT    = 3'd5;

    // datetime layout YYYY-MM-DD HH:MM:SS
    localparam int unsigned DT_LEN      = 19;
    localparam logic [4:0]  DT_YEAR_END = 5'd3;
    localparam logic [4:0]  DT_MON_END  = 5'd6;
    localparam logic [4:0]  DT_DAY_END  = 5'd9;
    localparam logic [4:0]  DT_HOUR_END = 5'd12;
    localparam logic [4:0]  DT_MIN_END  = 5'd15;
    localparam logic [4:0]  DT_SEC_END  = 5'd18;
    localparam logic [4:0]  DT_DASH_A   = 5'd4;
    localparam logic [4:0]  DT_DASH_B   = 5'd7;
    localparam logic [4:0]  DT_SPACE    = 5'd10;
    localparam logic [4:0]  DT_COLON_A  = 5'd13;
    localparam logic [4:0]  DT_COLON_B  = 5'd16;

    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    // recogniser states for numbers and identifiers
    typedef enum logic [2:0] {
        ST_START     = 3'd0,
        ST_SIGN      = 3'd1,
        ST_INT       = 3'd2,
        ST_DOT_AFTER = 3'd3,
        ST_DOT_ONLY  = 3'd4,
        ST_FRAC      = 3'd5,
        ST_IDENT     = 3'd6
    } t_syn_state;

    // one input beat
    typedef struct packed {
        logic [7:0]  ch;
        logic [2:0]  value_type;
        logic [15:0] length_limit;
        logic        is_last;
        logic        empty_value;
    } t_beat;

    // one verdict
    typedef struct packed {
        logic       valid_res;
        logic [2:0] error_code;
    } t_result;

    // days in month, month 1..12
    function automatic logic [4:0] month_days(input logic [3:0] month);
        logic [4:0] d;
        unique case (month)
            4'd2:                      d = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    // separator expected at a non-digit datetime position
    function automatic logic [7:0] dt_sep(input logic [4:0] pos);
        logic [7:0] s;
        unique case (pos)
            DT_DASH_A, DT_DASH_B:   s = CH_DASH;
            DT_SPACE:               s = CH_SPACE;
            default:                s = CH_COLON;
        endcase
        return s;
    endfunction

    function automatic logic dt_is_sep(input logic [4:0] pos);
        return (pos == DT_DASH_A) || (pos == DT_DASH_B) || (pos == DT_SPACE) ||
               (pos == DT_COLON_A) || (pos == DT_COLON_B);
    endfunction

endpackage

[design/sfvv_in_stage.sv]
// sfvv_in_stage: input register for the character stream
// depends on sfvv_pkg for the beat struct
module sfvv_in_stage
    import sfvv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // ch [7:0], length_limit [23:8]
    input  logic        i_s_axis_tlast,
    input  logic [3:0]  i_s_axis_tuser,  // value_type [2:0], empty_value [3]
    input  logic        i_advance,
    output logic        o_valid,
    output t_beat       o_beat
);

    logic  r_valid;
    t_beat r_beat;

    assign o_s_axis_tready = !r_valid || i_advance;
    assign o_valid         = r_valid;
    assign o_beat          = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_beat.ch           <= i_s_axis_tdata[7:0];
            r_beat.length_limit <= i_s_axis_tdata[23:8];
            r_beat.value_type   <= i_s_axis_tuser[2:0];
            r_beat.empty_value  <= i_s_axis_tuser[3];
            r_beat.is_last      <= i_s_axis_tlast;
        end
    end

endmodule

[design/sfvv_year_leap.sv]
// sfvv_year_leap: two-stage gregorian leap-year flag from the saved year
// depends on sfvv_pkg (no items used beyond the common import)
module sfvv_year_leap
    import sfvv_pkg::*;
(
    input  logic        i_clk,
    input  logic [13:0] i_year,
    output logic        o_leap
);

    // floor(y / 100) by reciprocal, exact for any 14-bit year
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int unsigned RECIP_SHIFT = 19;

    logic [26:0] prod;
    logic [13:0] hundreds_x100;
    logic [7:0]  r_q;
    logic [13:0] r_year;
    logic        r_leap;
    logic        rem_zero;

    assign prod          = {13'd0, i_year} * {14'd0, RECIP_100};
    assign hundreds_x100 = 14'({6'd0, r_q} * 14'd100);
    assign rem_zero      = (r_year == hundreds_x100);
    assign o_leap        = r_leap;

    always_ff @(posedge i_clk) begin
        r_q    <= prod[RECIP_SHIFT +: 8];
        r_year <= i_year;
        // divisible by 400, or by 4 and not by 100
        r_leap <= rem_zero ? (r_q[1:0] == 2'b00) : (r_year[1:0] == 2'b00);
    end

endmodule

[design/sfvv_check.sv]
// sfvv_check: per-value state and character checking, verdict at value end
// depends on sfvv_pkg for types, codes and datetime tables
module sfvv_check
    import sfvv_pkg::*;
#(
    parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  t_beat       i_beat,
    input  logic        i_leap,
    output logic [13:0] o_year,
    output logic        o_done,
    output t_result     o_result
);

    localparam int unsigned CW = $clog2(MAX_LENGTH + 1);
    localparam logic [CW-1:0] CountMax = CW'(MAX_LENGTH);
    localparam logic [15:0]   LimitMax = 16'(MAX_LENGTH);
    localparam logic [CW-1:0] DtLen    = CW'(DT_LEN);

    typedef struct packed {
        logic       reject;
        t_syn_state next;
    } t_num_step;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ)) ||
               (c == CH_UNDER);
    endfunction

    function automatic t_num_step num_step(input t_syn_state s, input logic [7:0] c,
                                           input logic allow_dot);
        t_num_step r;
        logic      sign;
        logic      dig;
        logic      dot;
        sign     = (c == CH_DASH) || (c == CH_PLUS);
        dig      = is_digit(c);
        dot      = allow_dot && (c == CH_DOT);
        r.reject = 1'b0;
        r.next   = s;
        unique case (s)
            ST_START: begin
                if (sign)      r.next = ST_SIGN;
                else if (dig)  r.next = ST_INT;
                else if (dot)  r.next = ST_DOT_ONLY;
                else           r.reject = 1'b1;
            end
            ST_SIGN: begin
                if (dig)       r.next = ST_INT;
                else if (dot)  r.next = ST_DOT_ONLY;
                else           r.reject = 1'b1;
            end
            ST_INT: begin
                if (dig)       r.next = ST_INT;
                else if (dot)  r.next = ST_DOT_AFTER;
                else           r.reject = 1'b1;
            end
            ST_DOT_AFTER: begin
                if (dig && allow_dot) r.next = ST_DOT_AFTER;
                else                  r.reject = 1'b1;
            end
            ST_DOT_ONLY, ST_FRAC: begin
                if (dig && allow_dot) r.next = ST_FRAC;
                else                  r.reject = 1'b1;
            end
            default: begin
                r.reject = 1'b1;
            end
        endcase
        return r;
    endfunction

    logic [CW-1:0] r_count,  n_count;
    t_syn_state    r_state,  n_state;
    logic          r_failed, n_failed;
    logic [13:0]   r_acc,    n_acc;
    logic [13:0]   r_year,   n_year;
    logic [6:0]    r_month,  n_month;

    logic [15:0]   limit_eff;
    logic [17:0]   acc_wide;
    logic [13:0]   acc_new;
    logic [4:0]    dt_pos;
    logic [4:0]    day_lim;
    t_num_step     nstep;
    logic          done;
    t_result       result;

    assign limit_eff = (i_beat.length_limit > LimitMax) ? LimitMax : i_beat.length_limit;
    assign dt_pos    = r_count[4:0];
    assign acc_wide  = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) +
                       {10'd0, i_beat.ch - CH_ZERO};
    assign acc_new   = acc_wide[13:0];
    assign nstep     = num_step(r_state, i_beat.ch, i_beat.value_type == TYPE_DOUBLE);
    assign done      = i_fire && (i_beat.is_last || i_beat.empty_value);

    // day ceiling for the saved month; zero when the month is out of range
    always_comb begin
        day_lim = 5'd0;
        if ((r_month >= 7'd1) && (r_month <= 7'd12)) begin
            day_lim = month_days(r_month[3:0]);
            if ((r_month == 7'd2) && i_leap) day_lim = 5'd29;
        end
    end

    // character step
    always_comb begin
        n_count  = r_count;
        n_state  = r_state;
        n_failed = r_failed;
        n_acc    = r_acc;
        n_year   = r_year;
        n_month  = r_month;
        if (!i_beat.empty_value) begin
            unique case (i_beat.value_type)
                TYPE_INT, TYPE_DOUBLE: begin
                    if (nstep.reject) n_failed = 1'b1;
                    else              n_state  = nstep.next;
                end
                TYPE_DATETIME: begin
                    if (r_count >= DtLen) begin
                        n_failed = 1'b1;
                    end else if (dt_is_sep(dt_pos)) begin
                        if (i_beat.ch != dt_sep(dt_pos)) n_failed = 1'b1;
                    end else if (!is_digit(i_beat.ch)) begin
                        n_failed = 1'b1;
                    end else begin
                        n_acc = acc_new;
                        unique case (dt_pos)
                            DT_YEAR_END: begin
                                n_year = acc_new;
                                n_acc  = '0;
                            end
                            DT_MON_END: begin
                                n_month = acc_new[6:0];
                                if ((acc_new < 14'd1) || (acc_new > 14'd12)) n_failed = 1'b1;
                                n_acc = '0;
                            end
                            DT_DAY_END: begin
                                if ((acc_new < 14'd1) || (acc_new > {9'd0, day_lim}))
                                    n_failed = 1'b1;
                                n_acc = '0;
                            end
                            DT_HOUR_END: begin
                                if (acc_new > 14'd23) n_failed = 1'b1;
                                n_acc = '0;
                            end
                            DT_MIN_END, DT_SEC_END: begin
                                if (acc_new > 14'd59) n_failed = 1'b1;
                                n_acc = '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                TYPE_VARCHAR: begin
                    if (16'(r_count) >= limit_eff) n_failed = 1'b1;
                end
                TYPE_IDENT: begin
                    unique case (r_state)
                        ST_START: begin
                            if (is_alpha(i_beat.ch)) n_state  = ST_IDENT;
                            else                     n_failed = 1'b1;
                        end
                        ST_IDENT: begin
                            if (!(is_alpha(i_beat.ch) || is_digit(i_beat.ch))) n_failed = 1'b1;
                        end
                        default: begin
                            n_failed = 1'b1;
                        end
                    endcase
                end
                default: begin
                end
            endcase
            if (r_count != CountMax) n_count = r_count + 1'b1;
        end
    end

    // verdict on the state after this character
    always_comb begin
        result.error_code = ERR_OK;
        unique case (i_beat.value_type)
            TYPE_INT: begin
                if (n_failed || (n_state != ST_INT)) result.error_code = ERR_INT;
            end
            TYPE_DOUBLE: begin
                if (n_failed || !((n_state == ST_INT) || (n_state == ST_DOT_AFTER) ||
                                  (n_state == ST_FRAC)))
                    result.error_code = ERR_DOUBLE;
            end
            TYPE_DATETIME: begin
                if (n_failed || (n_count != DtLen)) result.error_code = ERR_DATETIME;
            end
            TYPE_VARCHAR: begin
                if (n_failed) result.error_code = ERR_LENGTH;
            end
            TYPE_IDENT: begin
                if (n_failed || (n_state != ST_IDENT)) result.error_code = ERR_IDENT;
            end
            default: begin
            end
        endcase
        result.valid_res = (result.error_code == ERR_OK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || done) begin
            r_count  <= '0;
            r_state  <= ST_START;
            r_failed <= 1'b0;
            r_acc    <= '0;
            r_year   <= '0;
            r_month  <= '0;
        end else if (i_fire) begin
            r_count  <= n_count;
            r_state  <= n_state;
            r_failed <= n_failed;
            r_acc    <= n_acc;
            r_year   <= n_year;
            r_month  <= n_month;
        end
    end

    assign o_year   = r_year;
    assign o_done   = done;
    assign o_result = result;

endmodule

[design/sfvv_out_stage.sv]
// sfvv_out_stage: result register on the verdict stream
// depends on sfvv_pkg for the result struct
module sfvv_out_stage
    import sfvv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_result,
    output logic       o_free,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata   // valid_res [0], error_code [3:1], zeros [7:4]
);

    logic    r_valid;
    t_result r_result;

    assign o_free          = !r_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {4'd0, r_result.error_code, r_result.valid_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

[design/sql_field_value_validator_unit.sv]
// sql_field_value_validator_unit: top level of the field value validator
// depends on sfvv_pkg, sfvv_in_stage, sfvv_year_leap, sfvv_check, sfvv_out_stage

// The block checks a field value, one character per beat, against the type
// carried with each beat: signed integer, decimal double, datetime in the
// exact form YYYY-MM-DD HH:MM:SS (month, day with gregorian leap years, hour,
// minute and second range checked), VARCHAR limited to length_limit
// characters (capped at MAX_LENGTH), unchecked text, or SQL identifier.
// Type codes 6 and 7 behave as unchecked text. A beat with tlast set, or with
// the empty flag set (its character is then ignored), ends the value and
// yields one verdict beat: valid_res and an error code, 0 meaning ok. The
// state then clears for the next value. Each beat is held in the input
// register until the output register can take the outcome; the checking
// logic then updates the per-value state and, on a value's last beat,
// loads the verdict into the output register at that same clock edge. A new
// beat is accepted every cycle while the verdict side keeps draining. The
// leap-year flag is computed in a two-stage side pipeline from the saved
// year, well ahead of its use at the day field.
module sql_field_value_validator_unit
    import sfvv_pkg::*;
#(
    parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // ch [7:0], length_limit [23:8]
    input  logic        i_s_axis_tlast,   // is_last
    input  logic [3:0]  i_s_axis_tuser,   // value_type [2:0], empty_value [3]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata    // valid_res [0], error_code [3:1], zeros [7:4]
);

    logic        advance;   // output register can take this cycle's outcome
    logic        beat_valid;
    t_beat       beat;
    logic        fire;      // registered beat is processed this cycle
    logic [13:0] year;
    logic        leap;
    logic        done;
    t_result     result;

    assign fire = beat_valid && advance;

    // input register
    sfvv_in_stage u_in (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_advance       (advance),
        .o_valid         (beat_valid),
        .o_beat          (beat)
    );

    // leap flag from the saved year, refreshed every cycle
    sfvv_year_leap u_leap (
        .i_clk  (i_clk),
        .i_year (year),
        .o_leap (leap)
    );

    // per-value state and verdict
    sfvv_check #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_beat   (beat),
        .i_leap   (leap),
        .o_year   (year),
        .o_done   (done),
        .o_result (result)
    );

    // verdict register
    sfvv_out_stage u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (done),
        .i_result        (result),
        .o_free          (advance),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule
